### src/mpc_pkg.sv
// ----------------------------------------------------------------------------
// mpc_pkg: shared types and constants of the memory pattern checker
// Holds the pattern codes, register indexes, the count limit and the item
// that travels from the pattern front end to the checking back end.
// ----------------------------------------------------------------------------
package mpc_pkg;

    // Tested region size and the saturation point of the error count.
    localparam int REGION_WORDS   = 16384;
    localparam int COUNT_W        = 15;
    localparam int COUNT_FIELD_MX = 32767;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT =
        COUNT_W'((REGION_WORDS > COUNT_FIELD_MX) ? COUNT_FIELD_MX : REGION_WORDS);

    // Field widths.
    localparam int INDEX_W = 14;
    localparam int WORD_W  = 32;
    localparam int SEL_W   = 3;

    // Stream payload widths (fields packed from the low bit, padded to bytes).
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 128;

    // Pattern codes.
    localparam logic [SEL_W-1:0] PAT_ZEROS  = 3'd0;
    localparam logic [SEL_W-1:0] PAT_ONES   = 3'd1;
    localparam logic [SEL_W-1:0] PAT_WALK   = 3'd2;
    localparam logic [SEL_W-1:0] PAT_SEQ    = 3'd3;
    localparam logic [SEL_W-1:0] PAT_RANDOM = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_IDX_SELECT = 1'b0;
    localparam logic CFG_IDX_SEED   = 1'b1;

    // Constants of the patterns.
    localparam logic [WORD_W-1:0] MIX_CONST  = 32'hDEAD_BEEF;
    localparam logic [WORD_W-1:0] SEED_RESET = 32'h1234_5678;
    localparam logic [WORD_W-1:0] ALL_ONES   = 32'hFFFF_FFFF;

    // Classified word handed from the front end to the back end.
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [WORD_W-1:0]  actual;
        logic [WORD_W-1:0]  expected;
        logic               mismatch;
        logic               start;
    } t_item;

    localparam int ITEM_W = $bits(t_item);

    // Expected word for one index under the selected pattern.
    function automatic logic [WORD_W-1:0] pattern_word(
        input logic [SEL_W-1:0]   sel,
        input logic [WORD_W-1:0]  seed,
        input logic [INDEX_W-1:0] idx
    );
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] idx_w;
        logic [WORD_W-1:0] res;
        idx_w = WORD_W'(idx);
        x     = idx_w ^ seed ^ MIX_CONST;
        x     = x ^ (x << 13);
        x     = x ^ (x >> 17);
        x     = x ^ (x << 5);
        unique case (sel)
            PAT_ONES:   res = ALL_ONES;
            PAT_WALK:   res = WORD_W'(1) << idx[4:0];
            PAT_SEQ:    res = idx_w + seed;
            PAT_RANDOM: res = x;
            default:    res = '0;
        endcase
        return res;
    endfunction

endpackage

### src/mpc_front.sv
// ----------------------------------------------------------------------------
// mpc_front: configuration registers and pattern front end
// Accepts read-back beats, forms the expected word and the mismatch flag,
// and holds the classified item in a register until the queue takes it.
// ----------------------------------------------------------------------------
module mpc_front
    import mpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,
    // Input beat
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [INDEX_W-1:0]   i_index,
    input  logic [WORD_W-1:0]    i_actual,
    input  logic                 i_start,
    // Classified item towards the queue
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_item                o_item
);

    logic [SEL_W-1:0]  r_sel;
    logic [WORD_W-1:0] r_seed;
    logic              r_valid;
    t_item             r_item;
    t_item             n_item;
    logic              take;

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel  <= PAT_ZEROS;
            r_seed <= SEED_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IDX_SELECT: r_sel  <= i_cfg_data[SEL_W-1:0];
                CFG_IDX_SEED:   r_seed <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // Pattern generation and compare for the incoming beat.
    always_comb begin
        n_item          = '0;
        n_item.index    = i_index;
        n_item.actual   = i_actual;
        n_item.start    = i_start;
        n_item.expected = pattern_word(r_sel, r_seed, i_index);
        n_item.mismatch = (i_actual != n_item.expected);
    end

    // Output register: refills whenever it is empty or being drained.
    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### src/mpc_queue.sv
// ----------------------------------------------------------------------------
// mpc_queue: two-entry item queue
// Decouples the front end from the back end so that each side can stall
// on its own while a beat per cycle still flows through.
// ----------------------------------------------------------------------------
module mpc_queue
    import mpc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_valid,
    output logic   o_push_ready,
    input  t_item  i_push_item,
    output logic   o_pop_valid,
    input  logic   i_pop_ready,
    output t_item  o_pop_item
);

    t_item       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        push;
    logic        pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_item   = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

### src/mpc_back.sv
// ----------------------------------------------------------------------------
// mpc_back: error accounting back end
// Takes classified items, keeps the saturating error count and the first
// mismatch capture, and holds each result in an output register.
// ----------------------------------------------------------------------------
module mpc_back
    import mpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Classified item from the queue
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_item                i_item,
    // Result beat
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [WORD_W-1:0]    o_expected,
    output logic                 o_mismatch,
    output logic [COUNT_W-1:0]   o_error_total,
    output logic [INDEX_W-1:0]   o_cap_index,
    output logic [WORD_W-1:0]    o_cap_expected,
    output logic [WORD_W-1:0]    o_cap_actual
);

    logic               r_valid;
    logic [WORD_W-1:0]  r_expected;
    logic               r_mismatch;
    logic [COUNT_W-1:0] r_count;
    logic [INDEX_W-1:0] r_cap_index;
    logic [WORD_W-1:0]  r_cap_expected;
    logic [WORD_W-1:0]  r_cap_actual;

    logic [COUNT_W-1:0] base_count;
    logic [COUNT_W-1:0] n_count;
    logic [INDEX_W-1:0] n_cap_index;
    logic [WORD_W-1:0]  n_cap_expected;
    logic [WORD_W-1:0]  n_cap_actual;
    logic               take;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    // State update: a start beat clears first, then the mismatch is counted.
    always_comb begin
        base_count     = i_item.start ? '0 : r_count;
        n_count        = base_count;
        n_cap_index    = i_item.start ? '0 : r_cap_index;
        n_cap_expected = i_item.start ? '0 : r_cap_expected;
        n_cap_actual   = i_item.start ? '0 : r_cap_actual;
        if (i_item.mismatch && (base_count < COUNT_LIMIT)) begin
            if (base_count == '0) begin
                n_cap_index    = i_item.index;
                n_cap_expected = i_item.expected;
                n_cap_actual   = i_item.actual;
            end
            n_count = base_count + COUNT_W'(1);
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Accounting state; it also serves as the held result fields.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_cap_index    <= '0;
            r_cap_expected <= '0;
            r_cap_actual   <= '0;
        end else if (take) begin
            r_count        <= n_count;
            r_cap_index    <= n_cap_index;
            r_cap_expected <= n_cap_expected;
            r_cap_actual   <= n_cap_actual;
        end
    end

    // Per-beat result fields.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_expected <= i_item.expected;
            r_mismatch <= i_item.mismatch;
        end
    end

    assign o_valid        = r_valid;
    assign o_expected     = r_expected;
    assign o_mismatch     = r_mismatch;
    assign o_error_total  = r_count;
    assign o_cap_index    = r_cap_index;
    assign o_cap_expected = r_cap_expected;
    assign o_cap_actual   = r_cap_actual;

endmodule

### src/memory_pattern_checker.sv
// Path: an input beat is held in the front register, then in a queue entry,
// then in the back end output register, which presents the result beat.
// Throughput: one beat per cycle while i_m_axis_tready is held high; the front
// and back end output registers take a beat as the last leaves, the queue when not full.
// Reset: synchronous, active low; pattern select 0, seed 0x12345678, the
// error count and the first mismatch capture clear to zero.
// ----------------------------------------------------------------------------
// memory_pattern_checker: memory test pattern generator and readback checker
// Forms the expected word for each index, flags mismatches, counts them with
// saturation and captures the first mismatch of each pass.
// ----------------------------------------------------------------------------
module memory_pattern_checker
    import mpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [WORD_W-1:0]     i_cfg_data,
    // Input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [13:0] word_index, [45:14] read_word, [47:46] zero
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // [0] start_pass
    input  logic                  i_s_axis_tuser,
    // Result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [31:0] expected_word, [46:32] error_total, [60:47] first_bad_index,
    // [92:61] first_bad_expected, [124:93] first_bad_actual, [127:125] zero
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    // [0] mismatch
    output logic                  o_m_axis_tuser
);

    logic               front_valid;
    logic               front_ready;
    t_item              front_item;
    logic               queue_valid;
    logic               queue_ready;
    t_item              queue_item;
    logic [WORD_W-1:0]  expected;
    logic [COUNT_W-1:0] error_total;
    logic [INDEX_W-1:0] cap_index;
    logic [WORD_W-1:0]  cap_expected;
    logic [WORD_W-1:0]  cap_actual;

    // Pattern front end.
    mpc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_index     (i_s_axis_tdata[INDEX_W-1:0]),
        .i_actual    (i_s_axis_tdata[INDEX_W+WORD_W-1:INDEX_W]),
        .i_start     (i_s_axis_tuser),
        .o_valid     (front_valid),
        .i_ready     (front_ready),
        .o_item      (front_item)
    );

    // Queue between the two halves.
    mpc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_item  (front_item),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (queue_ready),
        .o_pop_item   (queue_item)
    );

    // Error accounting back end.
    mpc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (queue_valid),
        .o_ready        (queue_ready),
        .i_item         (queue_item),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_expected     (expected),
        .o_mismatch     (o_m_axis_tuser),
        .o_error_total  (error_total),
        .o_cap_index    (cap_index),
        .o_cap_expected (cap_expected),
        .o_cap_actual   (cap_actual)
    );

    // Pack the result fields from the low bit up.
    assign o_m_axis_tdata = {3'b000, cap_actual, cap_expected, cap_index,
                             error_total, expected};

endmodule
